@@ design/gaussian_inverse_cdf_assert.svh @@
// Assertion macros for the Gaussian inverse-CDF sample generator.
// Used by the top level only; needs nothing else.
`ifndef GAUSSIAN_INVERSE_CDF_ASSERT_SVH
`define GAUSSIAN_INVERSE_CDF_ASSERT_SVH

// same-cycle implication
`define GIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define GIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ design/gic_pkg.sv @@
// Shared types, constants and polynomial coefficients for the Gaussian inverse-CDF block.
// No dependencies.
`timescale 1ns / 1ps
package gic_pkg;

    typedef logic signed [39:0] poly_t;
    typedef logic signed [27:0] dlt_t;
    typedef logic [29:0] wq24_t;
    typedef logic [26:0] root_t;
    typedef logic [1:0] reg_idx_t;

    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [23:0] y24;
    } side_t;

    localparam reg_idx_t REG_MEAN  = 2'd0;
    localparam reg_idx_t REG_STD   = 2'd1;
    localparam reg_idx_t REG_TRUNC = 2'd2;

    localparam logic [23:0] ONE_Q23   = 24'd8388608;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [32:0] SQRT2_Q32 = 33'd6074001000;
    localparam logic [23:0] STD_RST   = 24'd65536;
    localparam wq24_t       FIVE_Q24  = 30'd83886080;
    localparam wq24_t       HALF5_Q24 = 30'd41943040;
    localparam root_t       THREE_Q24 = 27'd50331648;
    localparam logic signed [35:0] OUT_MAX = 36'sd8388607;
    localparam logic signed [35:0] OUT_MIN = -36'sd8388608;
    localparam logic [23:0] OUT_MIN_CODE = 24'h800000;

    localparam poly_t CENTRAL_COEF [9] = '{
        40'sd121, 40'sd1474, -40'sd15133, -40'sd18861, 40'sd938798, -40'sd5384708,
        -40'sd17943006, 40'sd1059313856, 40'sd6448504314
    };
    localparam poly_t TAIL_COEF [9] = '{
        -40'sd859914, 40'sd433579, 40'sd5795385, -40'sd15777255, 40'sd24650998,
        -40'sd32738222, 40'sd40539640, 40'sd4302157329, 40'sd12167542792
    };

    function automatic poly_t coef_at(input logic central, input int idx);
        return central ? CENTRAL_COEF[idx] : TAIL_COEF[idx];
    endfunction

endpackage

@@ design/gic_front.sv @@
// Front end: 2U-1, scaling by k, q = 1 - y^2. Three register stages.
// Depends on gic_pkg.
`timescale 1ns / 1ps
module gic_front #(
    parameter int UNIFORM_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [UNIFORM_BITS-1:0] u,
    input  logic [23:0]             trunc,
    output logic                    out_vld,
    output logic [32:0]             q,
    output gic_pkg::side_t          side
);

    localparam logic [UNIFORM_BITS-1:0] MID = {1'b1, {(UNIFORM_BITS-1){1'b0}}};

    logic                    vld1_reg, vld2_reg, vld3_reg;
    logic                    zero1_reg, zero2_reg, neg1_reg, neg2_reg;
    logic [32:0]             tm1_reg, tm1_next;
    logic [31:0]             ym2_reg, ym2_next;
    logic [32:0]             q3_reg, q3_next;
    gic_pkg::side_t          side3_reg;
    logic [UNIFORM_BITS-1:0] diff;
    logic [23:0]             k;
    logic [56:0]             prod;
    logic [63:0]             sq;

    always_comb
    begin
        diff     = u[UNIFORM_BITS-1] ? (u - MID) : (MID - u);
        tm1_next = {diff, {(33-UNIFORM_BITS){1'b0}}};
        k        = (trunc > gic_pkg::ONE_Q23) ? gic_pkg::ONE_Q23 : trunc;
        prod     = 57'(tm1_reg) * 57'(k);
        ym2_next = (prod[56:55] != 2'b00) ? '1 : prod[54:23];
        sq       = 64'(ym2_reg) * 64'(ym2_reg);
        q3_next  = 33'h1_0000_0000 - {1'b0, sq[63:32]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero1_reg      <= (u == '0);
            neg1_reg       <= ~u[UNIFORM_BITS-1];
            tm1_reg        <= tm1_next;
            zero2_reg      <= zero1_reg;
            neg2_reg       <= neg1_reg;
            ym2_reg        <= ym2_next;
            q3_reg         <= q3_next;
            side3_reg.zero <= zero2_reg;
            side3_reg.neg  <= neg2_reg;
            side3_reg.y24  <= ym2_reg[31:8];
        end
    end

    assign out_vld = vld3_reg;
    assign q       = q3_reg;
    assign side    = side3_reg;

endmodule

@@ design/gic_neglog.sv @@
// w = -ln(q / 2^32) in Q.24: normalise, 24 squaring stages, scale by ln2.
// Depends on gic_pkg.
`timescale 1ns / 1ps
module gic_neglog (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  logic [32:0]    q,
    input  gic_pkg::side_t side_in,
    output logic           out_vld,
    output gic_pkg::wq24_t w,
    output gic_pkg::side_t side_out
);

    localparam int NSQ = 24;
    localparam int NST = NSQ + 3;

    logic           vld_reg  [NST];
    gic_pkg::side_t side_reg [NST];
    logic [30:0]    m_reg    [NSQ+1];
    logic [23:0]    frac_reg [NSQ+1];
    logic [5:0]     e_reg    [NSQ+1];
    logic [5:0]     e_next;
    logic [62:0]    norm;
    gic_pkg::wq24_t l24_reg, l24_next;
    gic_pkg::wq24_t w_reg;
    logic [61:0]    wprod;

    always_comb
    begin
        e_next = '0;
        for (int b = 0; b < 33; b++)
        begin
            if (q[b])
            begin
                e_next = 6'(b);
            end
        end
        norm     = {q, 30'b0} >> e_next;
        l24_next = {6'd32 - e_reg[NSQ], 24'b0} - 30'(frac_reg[NSQ]);
        wprod    = 62'(l24_reg) * 62'(gic_pkg::LN2_Q32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s < NST; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            m_reg[0]    <= norm[30:0];
            e_reg[0]    <= e_next;
            frac_reg[0] <= '0;
            l24_reg     <= l24_next;
            w_reg       <= wprod[61:32];
        end
    end

    for (genvar i = 1; i <= NSQ; i++)
    begin : g_sq
        logic [61:0] sq;
        logic [31:0] sh;
        assign sq = 62'(m_reg[i-1]) * 62'(m_reg[i-1]);
        assign sh = sq[61:30];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]    <= sh[31] ? sh[31:1] : sh[30:0];
                frac_reg[i] <= {frac_reg[i-1][22:0], sh[31]};
                e_reg[i]    <= e_reg[i-1];
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign side_out = side_reg[NST-1];
    assign w        = w_reg;

endmodule

@@ design/gic_sqrt.sv @@
// Floor square root of w in Q.24, one result bit per register stage.
// Depends on gic_pkg.
`timescale 1ns / 1ps
module gic_sqrt (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  gic_pkg::wq24_t w_in,
    input  gic_pkg::side_t side_in,
    output logic           out_vld,
    output gic_pkg::wq24_t w_out,
    output gic_pkg::root_t root,
    output gic_pkg::side_t side_out
);

    localparam int NB = 27;

    logic           vld_reg  [NB];
    gic_pkg::side_t side_reg [NB];
    gic_pkg::wq24_t w_reg    [NB];
    logic [30:0]    r_reg    [NB];
    gic_pkg::root_t q_reg    [NB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < NB; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    for (genvar j = 0; j < NB; j++)
    begin : g_bit
        localparam int I = NB - 1 - j;
        gic_pkg::wq24_t wp;
        gic_pkg::side_t sp;
        logic [30:0]    rp;
        gic_pkg::root_t qp;
        logic [53:0]    vbits;
        logic [30:0]    rsh;
        logic [30:0]    trial;
        if (j == 0)
        begin : g_first
            assign wp = w_in;
            assign sp = side_in;
            assign rp = '0;
            assign qp = '0;
        end
        else
        begin : g_next
            assign wp = w_reg[j-1];
            assign sp = side_reg[j-1];
            assign rp = r_reg[j-1];
            assign qp = q_reg[j-1];
        end
        assign vbits = {wp, 24'b0};
        assign rsh   = {rp[28:0], vbits[2*I+1 -: 2]};
        assign trial = {2'b00, qp, 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                w_reg[j]    <= wp;
                side_reg[j] <= sp;
                if (rsh >= trial)
                begin
                    r_reg[j] <= rsh - trial;
                    q_reg[j] <= {qp[25:0], 1'b1};
                end
                else
                begin
                    r_reg[j] <= rsh;
                    q_reg[j] <= {qp[25:0], 1'b0};
                end
            end
        end
    end

    assign out_vld  = vld_reg[NB-1];
    assign side_out = side_reg[NB-1];
    assign w_out    = w_reg[NB-1];
    assign root     = q_reg[NB-1];

endmodule

@@ design/gic_horner.sv @@
// Branch select and degree-8 Horner evaluation, two register stages per step.
// Depends on gic_pkg.
`timescale 1ns / 1ps
module gic_horner (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  gic_pkg::wq24_t w,
    input  gic_pkg::root_t root,
    input  gic_pkg::side_t side_in,
    output logic           out_vld,
    output gic_pkg::poly_t p,
    output gic_pkg::side_t side_out
);

    localparam int NSTEP = 8;
    localparam int NST   = 2 * NSTEP + 1;

    logic           vld_reg  [NST];
    gic_pkg::side_t side_reg [NST];
    gic_pkg::dlt_t  d_reg    [NST];
    logic           cen_reg  [NST];
    gic_pkg::poly_t p_reg    [NSTEP+1];
    logic [45:0]    prh_reg  [1:NSTEP];
    logic [46:0]    prl_reg  [1:NSTEP];
    logic           pn_reg   [1:NSTEP];
    logic           central;
    gic_pkg::dlt_t  d_next;

    always_comb
    begin
        central = (w < gic_pkg::FIVE_Q24);
        if (central)
        begin
            d_next = 28'(w) - 28'(gic_pkg::HALF5_Q24);
        end
        else
        begin
            d_next = 28'({1'b0, root}) - 28'({1'b0, gic_pkg::THREE_Q24});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            d_reg[0]    <= d_next;
            cen_reg[0]  <= central;
            p_reg[0]    <= gic_pkg::coef_at(central, 0);
            for (int s = 1; s < NST; s++)
            begin
                side_reg[s] <= side_reg[s-1];
                d_reg[s]    <= d_reg[s-1];
                cen_reg[s]  <= cen_reg[s-1];
            end
        end
    end

    for (genvar k = 1; k <= NSTEP; k++)
    begin : g_step
        gic_pkg::poly_t      pin;
        gic_pkg::dlt_t       din;
        logic [39:0]         pa;
        logic [27:0]         da;
        logic [65:0]         full;
        logic signed [42:0]  rs;
        gic_pkg::poly_t      c;
        assign pin  = p_reg[k-1];
        assign din  = d_reg[2*k-2];
        assign pa   = pin[39] ? 40'(-pin) : 40'(pin);
        assign da   = din[27] ? 28'(-din) : 28'(din);
        assign full = {prh_reg[k], 20'b0} + 66'(prl_reg[k]);
        assign rs   = pn_reg[k] ? -$signed({1'b0, full[65:24]}) : $signed({1'b0, full[65:24]});
        assign c    = gic_pkg::coef_at(cen_reg[2*k-1], k);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prl_reg[k] <= 47'(pa[19:0]) * 47'(da[26:0]);
                prh_reg[k] <= 46'(pa[38:20]) * 46'(da[26:0]);
                pn_reg[k]  <= pin[39] ^ din[27];
                p_reg[k]   <= 40'(43'(c) + rs);
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign side_out = side_reg[NST-1];
    assign p        = p_reg[NSTEP];

endmodule

@@ design/gaussian_inverse_cdf.sv @@
// Channel  | Dir | Signals                          | Contents
// s_       | in  | s_tvalid s_tready s_tdata        | uniform code U
// m_       | out | m_tvalid m_tready m_tdata m_tuser | sample x, saturation flag
// cfg_     | in  | cfg_wen cfg_addr cfg_wdata       | mean, sigma, truncation factor
// One item per clock sustained when not stalled; register stages: 3 front, 27 log, 27 sqrt,
// 17 Horner, 4 scale and 1 output register, most of them in the log squaring chain and the sqrt.
// Stalls freeze the whole pipe only when its last stage holds an item and the
// output register is full and not taken; otherwise bubbles are filled.
// rst_n clears all valid bits and loads register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "gaussian_inverse_cdf_assert.svh"
module gaussian_inverse_cdf #(
    parameter int UNIFORM_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((UNIFORM_BITS+7)/8)*8-1:0]     s_tdata,   // [UB-1:0] uniform_code
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [23:0]                           m_tdata,   // [23:0] sample_value
    output logic                                  m_tuser,   // [0] saturated
    input  logic                                  cfg_wen,
    input  gic_pkg::reg_idx_t                     cfg_addr,
    input  logic [23:0]                           cfg_wdata
);

    logic signed [23:0] mean_reg;
    logic [23:0]        std_reg, trunc_reg;
    logic [24:0]        s16_reg;
    logic [56:0]        s16_prod;
    logic               adv;

    logic               f_vld, l_vld, r_vld, h_vld;
    logic [32:0]        f_q;
    gic_pkg::side_t     f_side, l_side, r_side, h_side;
    gic_pkg::wq24_t     l_w, r_w;
    gic_pkg::root_t     r_root;
    gic_pkg::poly_t     h_p;

    logic               t1_vld_reg, t2_vld_reg, t3_vld_reg, fin_vld_reg;
    logic               t1_zero_reg, t2_zero_reg, t3_zero_reg, fin_zero_reg;
    logic               t1_zn_reg, t2_zn_reg, t3_zn_reg;
    logic [43:0]        zl_reg;
    logic [42:0]        zh_reg;
    logic [38:0]        zmag_reg;
    logic [44:0]        xl_reg;
    logic [43:0]        xh_reg;
    logic [23:0]        fin_x_reg, fin_x_next;
    logic               fin_sat_reg, fin_sat_next;
    logic               out_zero_reg;

    logic [39:0]        pa;
    logic [62:0]        zfull;
    logic [63:0]        xfull;
    logic signed [35:0] xs, xsum;

    assign adv      = !(fin_vld_reg && m_tvalid && !m_tready);
    assign s_tready = adv;
    assign s16_prod = 57'(std_reg) * 57'(gic_pkg::SQRT2_Q32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            std_reg   <= gic_pkg::STD_RST;
            trunc_reg <= gic_pkg::ONE_Q23;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                gic_pkg::REG_MEAN:  mean_reg  <= cfg_wdata;
                gic_pkg::REG_STD:   std_reg   <= cfg_wdata;
                gic_pkg::REG_TRUNC: trunc_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        s16_reg <= s16_prod[56:32];
    end

    gic_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(s_tvalid),
        .u(s_tdata[UNIFORM_BITS-1:0]), .trunc(trunc_reg),
        .out_vld(f_vld), .q(f_q), .side(f_side)
    );

    gic_neglog u_neglog (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(f_vld), .q(f_q),
        .side_in(f_side), .out_vld(l_vld), .w(l_w), .side_out(l_side)
    );

    gic_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(l_vld), .w_in(l_w),
        .side_in(l_side), .out_vld(r_vld), .w_out(r_w), .root(r_root),
        .side_out(r_side)
    );

    gic_horner u_horner (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_vld(r_vld), .w(r_w),
        .root(r_root), .side_in(r_side), .out_vld(h_vld), .p(h_p),
        .side_out(h_side)
    );

    always_comb
    begin
        pa    = h_p[39] ? 40'(-h_p) : 40'(h_p);
        zfull = {zh_reg, 20'b0} + 63'(zl_reg);
        xfull = {xh_reg, 20'b0} + 64'(xl_reg);
        xs    = t3_zn_reg ? -$signed({4'b0, xfull[63:32]}) : $signed({4'b0, xfull[63:32]});
        xsum  = xs + 36'(mean_reg);
        priority if (t3_zero_reg)
        begin
            fin_x_next   = gic_pkg::OUT_MIN_CODE;
            fin_sat_next = 1'b1;
        end
        else if (xsum > gic_pkg::OUT_MAX)
        begin
            fin_x_next   = 24'(gic_pkg::OUT_MAX);
            fin_sat_next = 1'b1;
        end
        else if (xsum < gic_pkg::OUT_MIN)
        begin
            fin_x_next   = gic_pkg::OUT_MIN_CODE;
            fin_sat_next = 1'b1;
        end
        else
        begin
            fin_x_next   = xsum[23:0];
            fin_sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg  <= 1'b0;
            t2_vld_reg  <= 1'b0;
            t3_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
            m_tvalid    <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                t1_vld_reg  <= h_vld;
                t2_vld_reg  <= t1_vld_reg;
                t3_vld_reg  <= t2_vld_reg;
                fin_vld_reg <= t3_vld_reg;
            end
            if (!m_tvalid || m_tready)
            begin
                m_tvalid <= fin_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zl_reg       <= 44'(pa[19:0]) * 44'(h_side.y24);
            zh_reg       <= 43'(pa[38:20]) * 43'(h_side.y24);
            t1_zn_reg    <= h_p[39] ^ h_side.neg;
            t1_zero_reg  <= h_side.zero;
            zmag_reg     <= zfull[62:24];
            t2_zn_reg    <= t1_zn_reg;
            t2_zero_reg  <= t1_zero_reg;
            xl_reg       <= 45'(zmag_reg[19:0]) * 45'(s16_reg);
            xh_reg       <= 44'(zmag_reg[38:20]) * 44'(s16_reg);
            t3_zn_reg    <= t2_zn_reg;
            t3_zero_reg  <= t2_zero_reg;
            fin_x_reg    <= fin_x_next;
            fin_sat_reg  <= fin_sat_next;
            fin_zero_reg <= t3_zero_reg;
        end
        if (!m_tvalid || m_tready)
        begin
            m_tdata      <= fin_x_reg;
            m_tuser      <= fin_sat_reg;
            out_zero_reg <= fin_zero_reg;
        end
    end

    `GIC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)
    `GIC_ASSERT_NEXT(a_last_stage_holds, clk, rst_n, !s_tready, fin_vld_reg && $stable(fin_x_reg))
    `GIC_ASSERT_IMPL(a_zero_code_out, clk, rst_n, m_tvalid && out_zero_reg, m_tuser && (m_tdata == gic_pkg::OUT_MIN_CODE))

endmodule

@@ tb/tb.sv @@
// Testbench for gaussian_inverse_cdf: streams uniform codes through the block
// and checks each sample against a fixed-point inverse-CDF predictor.
// Depends on gic_pkg and the gaussian_inverse_cdf RTL.
`timescale 1ns / 1ps

class sample_board;
    logic [23:0] exp_value[$];
    logic        exp_sat[$];
    int          errors;

    function void note(logic [23:0] v, logic s);
        exp_value.push_back(v);
        exp_sat.push_back(s);
    endfunction

    function void check(logic [23:0] v, logic s);
        logic [23:0] ev;
        logic        es;
        if (exp_value.size() == 0)
        begin
            $error("unexpected item: sample_value %h", v);
            errors++;
            return;
        end
        ev = exp_value.pop_front();
        es = exp_sat.pop_front();
        if (ev !== v)
        begin
            $error("sample_value expected %h actual %h", ev, v);
            errors++;
        end
        if (es !== s)
        begin
            $error("saturated expected %0b actual %0b", es, s);
            errors++;
        end
    endfunction
endclass

module tb;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [23:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_wen = 0;
    gic_pkg::reg_idx_t cfg_addr = gic_pkg::REG_MEAN;
    logic [23:0]       cfg_wdata = '0;

    longint      mu;
    longint      sigma;
    longint      kf;
    sample_board board;

    gaussian_inverse_cdf #(.UNIFORM_BITS(24)) DUT (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic longint mul_trunc(longint a, longint b, int sh);
        bit          neg;
        logic [127:0] r;
        neg = (a < 0) != (b < 0);
        r = (128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b)) >> sh;
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint neg_ln(longint unsigned q);
        int              e;
        longint unsigned m, frac, l24;
        logic [127:0]    pr;
        e = 0;
        frac = 0;
        while (e < 40 && (q >> (e + 1)) != 0) e++;
        m = e >= 30 ? q >> (e - 30) : q << (30 - e);
        for (int i = 1; i <= 24; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m >>= 1;
                frac |= 64'd1 << (24 - i);
            end
        end
        l24 = (longint'(32 - e) << 24) - frac;
        pr = 128'(l24) * 128'(gic_pkg::LN2_Q32);
        return longint'(pr >> 32);
    endfunction

    function automatic longint poly_eval(bit central, longint d);
        longint p;
        p = central ? gic_pkg::CENTRAL_COEF[0] : gic_pkg::TAIL_COEF[0];
        for (int i = 1; i < 9; i++)
            p = (central ? longint'(gic_pkg::CENTRAL_COEF[i])
                         : longint'(gic_pkg::TAIL_COEF[i]))
                + mul_trunc(p, d, 24);
        return p;
    endfunction

    task automatic predict_sample(logic [23:0] code);
        longint unsigned u, tm, k, ym, q;
        longint          w, p, y24, z, s16, x;
        bit              neg, sat;
        u = code;
        if (u == 0)
        begin
            board.note(gic_pkg::OUT_MIN_CODE, 1'b1);
            return;
        end
        neg = 2 * u < (64'd1 << 24);
        tm = neg ? (64'd1 << 24) - 2 * u : 2 * u - (64'd1 << 24);
        tm <<= 8;
        k = kf > gic_pkg::ONE_Q23 ? gic_pkg::ONE_Q23 : kf;
        ym = (tm * k) >> 23;
        if (ym > 64'hFFFFFFFF) ym = 64'hFFFFFFFF;
        q = (64'd1 << 32) - ((ym * ym) >> 32);
        w = neg_ln(q);
        if (w < (longint'(5) << 24))
            p = poly_eval(1, w - (longint'(5) << 23));
        else
            p = poly_eval(0, int_sqrt(w << 24) - (longint'(3) << 24));
        y24 = ym >> 8;
        if (neg) y24 = -y24;
        z = mul_trunc(p, y24, 24);
        s16 = longint'((128'(sigma) * 128'(gic_pkg::SQRT2_Q32)) >> 32);
        x = mul_trunc(s16, z, 32) + mu;
        sat = 0;
        if (x > 8388607)
        begin
            x = 8388607;
            sat = 1;
        end
        if (x < -8388608)
        begin
            x = -8388608;
            sat = 1;
        end
        board.note(x[23:0], sat);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(gic_pkg::reg_idx_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_wen <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wen <= 0;
        case (idx)
            gic_pkg::REG_MEAN:  mu = longint'($signed(val));
            gic_pkg::REG_STD:   sigma = val;
            gic_pkg::REG_TRUNC: kf = val;
            default: ;
        endcase
    endtask

    task automatic send_code(logic [23:0] code, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= code;
        do @(posedge clk); while (!s_tready);
        predict_sample(code);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.exp_value.size() != 0) @(posedge clk);
        repeat (100) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_code();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'($urandom_range(0, 255));
        if (r == 1) return 24'hFFFFFF - 24'($urandom_range(0, 255));
        if (r == 2) return 24'h800000 + 24'($urandom_range(0, 64)) - 24'd32;
        return 24'($urandom);
    endfunction

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check(m_tdata, m_tuser);

    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 0;
                repeat (g) @(negedge clk);
            end
            m_tready <= 1;
        end
    end

    initial
    begin
        logic [23:0] dir_codes[$];
        board = new();
        mu = 0;
        sigma = 65536;
        kf = gic_pkg::ONE_Q23;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        dir_codes = '{24'h000000, 24'h000001, 24'h000002, 24'hFFFFFF, 24'hFFFFFE,
                      24'h800000, 24'h7FFFFF, 24'h800001, 24'h400000, 24'hC00000,
                      24'h555555, 24'hAAAAAA, 24'h000100, 24'hFFFF00, 24'h0F0F0F};
        foreach (dir_codes[i]) send_code(dir_codes[i], 0);
        drain();
        // tiny and huge sigma, offset means, factor extremes
        write_reg(gic_pkg::REG_STD, 24'hFFFFFF);
        write_reg(gic_pkg::REG_MEAN, 24'h7FFFFF);
        foreach (dir_codes[i]) send_code(dir_codes[i], 1);
        drain();
        write_reg(gic_pkg::REG_STD, 24'd0);
        write_reg(gic_pkg::REG_MEAN, 24'h800000);
        write_reg(gic_pkg::REG_TRUNC, 24'd0);
        for (int i = 0; i < 6; i++) send_code(dir_codes[i], 1);
        drain();
        write_reg(gic_pkg::REG_TRUNC, 24'hFFFFFF);
        write_reg(gic_pkg::REG_STD, 24'd40000);
        write_reg(gic_pkg::REG_MEAN, 24'd0);
        for (int i = 0; i < 6; i++) send_code(dir_codes[i], 1);
        drain();
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(gic_pkg::REG_MEAN, 24'($urandom));
            write_reg(gic_pkg::REG_STD,
                      ph == 0 ? 24'd65536 : 24'($urandom_range(0, 24'hFFFFFF)));
            write_reg(gic_pkg::REG_TRUNC,
                      ph == 0 ? gic_pkg::ONE_Q23 : 24'($urandom_range(0, 24'h900000)));
            for (int i = 0; i < 100; i++) send_code(rand_code(), ph != 2);
            drain();
        end
        if (board.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
